// ===== hdl/rth_pkg.sv =====
// rth_pkg: shared constants for the rgb_to_hue pipeline
// used by rth_prep, rth_div_cell and rgb_to_hue; depends on nothing

package rth_pkg;

	// width of the hue result, also the number of quotient cells
	localparam int HUE_W = 9;

	// degrees per sector and the sector offsets
	localparam int DEG_PER_SECTOR = 60;
	localparam int GREEN_OFFSET   = 120;
	localparam int BLUE_OFFSET    = 240;
	localparam int FULL_TURN      = 360;

	// bits of headroom above the channel width for the rounding numerator
	localparam int NUM_EXTRA_BITS = 10;

endpackage

// ===== hdl/rth_prep.sv =====
// rth_prep: two front cells, max/min/sector pick, then the rounding numerator
// and doubled span for the divider chain; depends on rth_pkg

module rth_prep #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic [CHANNEL_BITS-1:0]                       red,
	input  logic [CHANNEL_BITS-1:0]                       green,
	input  logic [CHANNEL_BITS-1:0]                       blue,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic [CHANNEL_BITS+rth_pkg::NUM_EXTRA_BITS-1:0] num,
	output logic [CHANNEL_BITS:0]                         den
);

	localparam int SW = CHANNEL_BITS + rth_pkg::NUM_EXTRA_BITS;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// stage 1: extremes, span, sector and signed channel difference
	logic [CHANNEL_BITS-1:0] mx, mn;
	sector_t                 sec;
	logic [CHANNEL_BITS:0]   diff;

	logic                    valid_s1;
	logic                    en_s1;
	logic [CHANNEL_BITS-1:0] span_s1;
	sector_t                 sec_s1;
	logic [CHANNEL_BITS:0]   diff_s1;

	// stage 2
	logic                    valid_s2;
	logic                    en_s2;
	logic [SW-1:0]           num_s2;
	logic [CHANNEL_BITS:0]   den_s2;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (mx == red) begin
			sec  = SEC_RED;
			diff = {1'b0, green} - {1'b0, blue};
		end else if (mx == green) begin
			sec  = SEC_GREEN;
			diff = {1'b0, blue} - {1'b0, red};
		end else begin
			sec  = SEC_BLUE;
			diff = {1'b0, red} - {1'b0, green};
		end
	end

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			span_s1 <= mx - mn;
			sec_s1  <= sec;
			diff_s1 <= diff;
		end
	end

	// stage 2 arithmetic: n = 60*diff + offset*span, wrapped by a full turn if negative
	logic signed [SW-1:0] diff_ext;
	logic signed [SW-1:0] span_ext;
	logic signed [SW-1:0] scaled;
	logic signed [SW-1:0] offset;
	logic signed [SW-1:0] n_raw;
	logic signed [SW-1:0] n_wrap;
	logic [SW-1:0]        num_c;
	logic [CHANNEL_BITS:0] den_c;

	always_comb begin
		diff_ext = {{(SW-CHANNEL_BITS-1){diff_s1[CHANNEL_BITS]}}, diff_s1};
		span_ext = {{(SW-CHANNEL_BITS){1'b0}}, span_s1};
		scaled   = diff_ext * SW'(rth_pkg::DEG_PER_SECTOR);
		case (sec_s1)
			SEC_RED:   offset = '0;
			SEC_GREEN: offset = span_ext * SW'(rth_pkg::GREEN_OFFSET);
			SEC_BLUE:  offset = span_ext * SW'(rth_pkg::BLUE_OFFSET);
			default:   offset = '0;
		endcase
		n_raw  = scaled + offset;
		n_wrap = n_raw[SW-1] ? n_raw + span_ext * SW'(rth_pkg::FULL_TURN) : n_raw;
		// round half up: floor((2n + d) / 2d)
		num_c  = (n_wrap << 1) + span_ext;
		// gray pixel: numerator is zero, any nonzero divisor yields zero
		den_c  = (span_s1 == '0) ? (CHANNEL_BITS+1)'(1) : {span_s1, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			num_s2 <= num_c;
			den_s2 <= den_c;
		end
	end

	assign out_valid = valid_s2;
	assign num       = num_s2;
	assign den       = den_s2;

endmodule

// ===== hdl/rth_div_cell.sv =====
// rth_div_cell: one quotient bit of the restoring divider chain
// compare/subtract against the divisor shifted by SHIFT; depends on rth_pkg

module rth_div_cell #(
	parameter int NUM_W = 18,
	parameter int DEN_W = 9,
	parameter int SHIFT = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [NUM_W-1:0]          rem_in,
	input  logic [DEN_W-1:0]          den_in,
	input  logic [rth_pkg::HUE_W-1:0] quot_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [NUM_W-1:0]          rem_out,
	output logic [DEN_W-1:0]          den_out,
	output logic [rth_pkg::HUE_W-1:0] quot_out
);

	logic                      valid_q;
	logic [NUM_W-1:0]          rem_q;
	logic [DEN_W-1:0]          den_q;
	logic [rth_pkg::HUE_W-1:0] quot_q;
	logic [NUM_W-1:0]          trial;
	logic                      fits;
	logic                      en;

	assign en       = !valid_q || out_ready;
	assign in_ready = en;
	assign trial    = NUM_W'(den_in) << SHIFT;
	assign fits     = rem_in >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			rem_q  <= fits ? rem_in - trial : rem_in;
			den_q  <= den_in;
			quot_q <= {quot_in[rth_pkg::HUE_W-2:0], fits};
		end
	end

	assign out_valid = valid_q;
	assign rem_out   = rem_q;
	assign den_out   = den_q;
	assign quot_out  = quot_q;

endmodule

// ===== hdl/rgb_to_hue.sv =====
// rgb_to_hue: hue in whole degrees of one RGB pixel per beat
// top level; depends on rth_pkg, rth_prep and rth_div_cell
//
//  channel   dir   handshake          tdata / tuser
//  s_        in    s_tvalid/s_tready  red, green, blue (CHANNEL_BITS each)
//  m_        out   m_tvalid/m_tready  hue_degrees (9 bits, 0..360)
//
// one pixel per clock sustained while m_tready is high; an input beat passes
// two front cells, then nine divider cells, one per quotient bit, on its way
// to the output beat, the last cell doubling as the output register
// arst_n clears every valid flag; payload registers are not reset
// each cell takes a new beat when it is empty or its neighbor takes its beat,
// so a stall on m_ only stops the cells that are full and bubbles collapse

module rgb_to_hue #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// red_level, green_level, blue_level from bit 0 up, zero-filled to bytes
	input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// hue_degrees in the low 9 bits, zero above
	output logic [15:0]                       m_tdata
);

	localparam int NUM_W = CHANNEL_BITS + rth_pkg::NUM_EXTRA_BITS;
	localparam int DEN_W = CHANNEL_BITS + 1;
	localparam int CELLS = rth_pkg::HUE_W;

	logic [CHANNEL_BITS-1:0] red_level;
	logic [CHANNEL_BITS-1:0] green_level;
	logic [CHANNEL_BITS-1:0] blue_level;

	// unpack the input beat
	assign red_level   = s_tdata[CHANNEL_BITS-1:0];
	assign green_level = s_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS];
	assign blue_level  = s_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS];

	// links between cells: index 0 is the prep output, index CELLS the last cell
	logic                      link_valid [CELLS+1];
	logic                      link_ready [CELLS+1];
	logic [NUM_W-1:0]          link_rem   [CELLS+1];
	logic [DEN_W-1:0]          link_den   [CELLS+1];
	logic [rth_pkg::HUE_W-1:0] link_quot  [CELLS+1];

	// front cells: sector, numerator with half-up rounding term, doubled span
	rth_prep #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.red       (red_level),
		.green     (green_level),
		.blue      (blue_level),
		.out_valid (link_valid[0]),
		.out_ready (link_ready[0]),
		.num       (link_rem[0]),
		.den       (link_den[0])
	);

	assign link_quot[0] = '0;

	// divider chain: cell k tests the divisor shifted by CELLS-1-k, msb first
	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		rth_div_cell #(
			.NUM_W (NUM_W),
			.DEN_W (DEN_W),
			.SHIFT (CELLS - 1 - k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[k]),
			.in_ready  (link_ready[k]),
			.rem_in    (link_rem[k]),
			.den_in    (link_den[k]),
			.quot_in   (link_quot[k]),
			.out_valid (link_valid[k+1]),
			.out_ready (link_ready[k+1]),
			.rem_out   (link_rem[k+1]),
			.den_out   (link_den[k+1]),
			.quot_out  (link_quot[k+1])
		);
	end

	// output beat straight from the last cell's registers
	assign link_ready[CELLS] = m_tready;
	assign m_tvalid          = link_valid[CELLS];
	assign m_tdata           = {{(16-rth_pkg::HUE_W){1'b0}}, link_quot[CELLS]};

endmodule
